// File: rtl/core/encoder_speed_position_tracker_defines.svh
// Assertion macros for the encoder speed and position tracker.
// Depends on nothing; included by modules that carry assertions.
`ifndef ENCODER_SPEED_POSITION_TRACKER_DEFINES_SVH
`define ENCODER_SPEED_POSITION_TRACKER_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define ESPT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define ESPT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/espt_pkg.sv
// Types and constants of the encoder speed and position tracker.
// Depends on nothing.
`default_nettype none

package espt_pkg;

   localparam int unsigned RPM_W = 26;
   localparam logic [RPM_W-1:0] RPM_US_NUM = 26'd60000000;
   localparam logic [16:0] ALPHA_ONE = 17'd65536;
   localparam int unsigned DIV_STEPS = 32;
   localparam int unsigned STEP_W = $clog2(DIV_STEPS);

   localparam int unsigned CSR_INDEX_W = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENCODER_PRESENT = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_REVERSE_DIRECTION = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PULSES_PER_REV = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA_Q16 = 8'd3;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_LOAD = 1'b1;

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_MUL  = 7'b0000010,
      S_CHK  = 7'b0000100,
      S_DIV  = 7'b0001000,
      S_FILT = 7'b0010000,
      S_ACC  = 7'b0100000,
      S_EMIT = 7'b1000000
   } state_type;

endpackage

`default_nettype wire

// File: rtl/core/encoder_speed_position_tracker.sv
// Encoder speed and position tracker: count delta, RPM quotient, smoothing filter.
// Depends on espt_pkg and encoder_speed_position_tracker_defines.svh.
//
// A tick with an encoder present and a nonzero count delta runs from acceptance
// to the next acceptance through the delta, the numerator and denominator
// products, the range check, the restoring divider, which yields one quotient
// bit per cycle, the filter multiply and accumulate and the result word. A tick
// whose quotient already overflows 32 bits at the range check skips the divider.
// A load, a tick with no encoder and a tick with a zero delta go straight to the
// result word. The result word sits in an output register, so a new word is
// accepted while the previous result waits; only completion waits on rsp_ready.
`default_nettype none

`include "encoder_speed_position_tracker_defines.svh"

module encoder_speed_position_tracker
   import espt_pkg::*;
#(
   parameter int unsigned COUNTER_WIDTH = 16,
   parameter int unsigned SPEED_FRAC_BITS = 8
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    csr_valid,
   output logic                   csr_ready,
   input  wire [CSR_INDEX_W-1:0]  csr_index,
   input  wire [31:0]             csr_wdata,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  wire                    req_op,
   input  wire [15:0]             req_counter_value,
   input  wire [15:0]             req_tick_period_us,
   input  wire signed [63:0]      req_load_position,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output logic signed [63:0]     rsp_position,
   output logic signed [31:0]     rsp_speed_rpm_q8,
   output logic signed [15:0]     rsp_count_delta,
   output logic                   rsp_speed_saturated
);

   localparam int unsigned CW = COUNTER_WIDTH;
   localparam int unsigned PROD_W = CW + RPM_W;
   localparam int unsigned NUM_W = PROD_W + SPEED_FRAC_BITS;
   localparam int unsigned HI_W = NUM_W - 32;
   localparam int unsigned CMP_W = (HI_W > 32) ? HI_W : 32;

   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic enc_present_ff, enc_present_in;
   logic reverse_ff, reverse_in;
   logic [15:0] ppr_ff, ppr_in;
   logic [16:0] alpha_ff, alpha_in;
   logic [CW-1:0] last_count_ff, last_count_in;
   logic [63:0] position_ff, position_in;
   logic [31:0] filt_ff, filt_in;
   logic [CW-1:0] delta_ff, delta_in;
   logic neg_ff, neg_in;
   logic [CW-1:0] mag_ff, mag_in;
   logic [15:0] dt_ff, dt_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [31:0] den_ff, den_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic sat_ff, sat_in;
   logic [50:0] prod_ff, prod_in;
   logic [63:0] rsp_position_ff, rsp_position_in;
   logic [31:0] rsp_speed_ff, rsp_speed_in;
   logic [15:0] rsp_delta_ff, rsp_delta_in;
   logic rsp_sat_ff, rsp_sat_in;

   logic req_fire;
   logic [CW-1:0] cur_cnt, raw_diff, delta_now;
   logic [15:0] ppr_eff;
   logic [16:0] alpha_eff;
   logic [PROD_W-1:0] rpm_prod;
   logic [HI_W-1:0] num_hi;
   logic [33:0] trial;
   logic sat_now;
   logic [31:0] speed_mag, raw_rpm;
   logic signed [32:0] fdiff;
   logic signed [17:0] alpha_s;
   logic signed [50:0] fprod;
   logic [51:0] fsum;

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign req_fire = req_valid && req_ready;

   assign cur_cnt = CW'(req_counter_value);
   assign raw_diff = cur_cnt - last_count_ff;
   assign delta_now = reverse_ff ? (CW'(0) - raw_diff) : raw_diff;
   assign ppr_eff = (ppr_ff == 16'd0) ? 16'd1 : ppr_ff;
   assign alpha_eff = (alpha_ff > ALPHA_ONE) ? ALPHA_ONE : alpha_ff;
   assign rpm_prod = PROD_W'(mag_ff) * PROD_W'(RPM_US_NUM);
   assign num_hi = num_ff[NUM_W-1:32];
   assign trial = {1'b0, rem_ff, quo_ff[31]} - {2'b00, den_ff};
   assign sat_now = sat_ff | quo_ff[31];
   assign speed_mag = sat_now ? (neg_ff ? 32'h8000_0000 : 32'h7FFF_FFFF) : quo_ff;
   assign raw_rpm = neg_ff ? (32'd0 - speed_mag) : speed_mag;
   assign fdiff = $signed({raw_rpm[31], raw_rpm}) - $signed({filt_ff[31], filt_ff});
   assign alpha_s = $signed({1'b0, alpha_eff});
   assign fprod = alpha_s * fdiff;
   assign fsum = {{4{filt_ff[31]}}, filt_ff, 16'd0} + {prod_ff[50], prod_ff} + 52'd32768;

   always_comb begin
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff;
      enc_present_in = enc_present_ff;
      reverse_in = reverse_ff;
      ppr_in = ppr_ff;
      alpha_in = alpha_ff;
      last_count_in = last_count_ff;
      position_in = position_ff;
      filt_in = filt_ff;
      delta_in = delta_ff;
      neg_in = neg_ff;
      mag_in = mag_ff;
      dt_in = dt_ff;
      num_in = num_ff;
      den_in = den_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      step_in = step_ff;
      sat_in = sat_ff;
      prod_in = prod_ff;
      rsp_position_in = rsp_position_ff;
      rsp_speed_in = rsp_speed_ff;
      rsp_delta_in = rsp_delta_ff;
      rsp_sat_in = rsp_sat_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ENCODER_PRESENT: enc_present_in = csr_wdata[0];
            CSR_REVERSE_DIRECTION: reverse_in = csr_wdata[0];
            CSR_PULSES_PER_REV: ppr_in = csr_wdata[15:0];
            CSR_ALPHA_Q16: alpha_in = csr_wdata[16:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               delta_in = '0;
               sat_in = 1'b0;
               state_in = S_EMIT;
               if (req_op == OP_LOAD) begin
                  position_in = req_load_position;
                  last_count_in = '0;
               end else if (enc_present_ff) begin
                  delta_in = delta_now;
                  last_count_in = cur_cnt;
                  position_in = position_ff + 64'($signed(delta_now));
                  neg_in = delta_now[CW-1];
                  mag_in = delta_now[CW-1] ? (CW'(0) - delta_now) : delta_now;
                  dt_in = (req_tick_period_us == 16'd0) ? 16'd1 : req_tick_period_us;
                  if (delta_now == '0) begin
                     filt_in = '0;
                  end else begin
                     state_in = S_MUL;
                  end
               end
            end
         end
         S_MUL: begin
            num_in = NUM_W'(rpm_prod) << SPEED_FRAC_BITS;
            den_in = {16'd0, dt_ff} * {16'd0, ppr_eff};
            state_in = S_CHK;
         end
         S_CHK: begin
            if (CMP_W'(num_hi) >= CMP_W'(den_ff)) begin
               sat_in = 1'b1;
               state_in = S_FILT;
            end else begin
               rem_in = 32'(num_hi);
               quo_in = num_ff[31:0];
               step_in = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (!trial[33]) begin
               rem_in = trial[31:0];
            end else begin
               rem_in = {rem_ff[30:0], quo_ff[31]};
            end
            quo_in = {quo_ff[30:0], !trial[33]};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = S_FILT;
            end
         end
         S_FILT: begin
            sat_in = sat_now;
            prod_in = fprod;
            state_in = S_ACC;
         end
         S_ACC: begin
            filt_in = fsum[47:16];
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_position_in = enc_present_ff ? position_ff : 64'd0;
               rsp_speed_in = enc_present_ff ? filt_ff : 32'd0;
               rsp_delta_in = 16'($signed(delta_ff));
               rsp_sat_in = sat_ff;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         enc_present_ff <= 1'b0;
         reverse_ff <= 1'b0;
         ppr_ff <= 16'd1;
         alpha_ff <= ALPHA_ONE;
         last_count_ff <= '0;
         position_ff <= '0;
         filt_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         enc_present_ff <= enc_present_in;
         reverse_ff <= reverse_in;
         ppr_ff <= ppr_in;
         alpha_ff <= alpha_in;
         last_count_ff <= last_count_in;
         position_ff <= position_in;
         filt_ff <= filt_in;
      end
   end

   always_ff @(posedge clock) begin
      delta_ff <= delta_in;
      neg_ff <= neg_in;
      mag_ff <= mag_in;
      dt_ff <= dt_in;
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      step_ff <= step_in;
      sat_ff <= sat_in;
      prod_ff <= prod_in;
      rsp_position_ff <= rsp_position_in;
      rsp_speed_ff <= rsp_speed_in;
      rsp_delta_ff <= rsp_delta_in;
      rsp_sat_ff <= rsp_sat_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_speed_rpm_q8 = rsp_speed_ff;
   assign rsp_count_delta = rsp_delta_ff;
   assign rsp_speed_saturated = rsp_sat_ff;

   `ESPT_ASSERT_NEXT(a_moving_tick_starts_mul, clock, reset,
      req_fire && req_op == OP_TICK && enc_present_ff && delta_now != '0,
      state_ff == S_MUL, "moving tick did not start the speed path")
   `ESPT_ASSERT_SAME(a_div_nonzero_den, clock, reset,
      state_ff == S_DIV, den_ff != 32'd0, "division by zero denominator")
   `ESPT_ASSERT_SAME(a_div_rem_below_den, clock, reset,
      state_ff == S_DIV, rem_ff < den_ff, "divider remainder out of range")
   `ESPT_ASSERT_NEXT(a_load_sets_state, clock, reset,
      req_fire && req_op == OP_LOAD,
      last_count_ff == '0 && position_ff == $past(req_load_position),
      "load did not set position and clear last count")

endmodule

`default_nettype wire
